@@ design/hbf_pkg.sv @@
// hbf_pkg: widths, constants, state and operand codes, and the command bundle
// shared by the harmonic bond force controller, datapath and top level.
// No dependencies.
package hbf_pkg;

	localparam int IN_W    = 288;
	localparam int OUT_W   = 280;
	localparam int CRD_W   = 32;
	localparam int DIFF_W  = 33;
	localparam int IDX_W   = 16;
	localparam int ROOT_W  = 34;
	localparam int RAD_W   = 68;
	localparam int SREM_W  = 36;
	localparam int AE_W    = 34;
	localparam int KU_W    = 58;
	localparam int EE_W    = 70;
	localparam int KUA_W   = 93;
	localparam int MP_W    = 128;
	localparam int MB_W    = 35;
	localparam int DV_W    = 94;
	localparam int DREM_W  = 35;
	localparam int F_W     = 48;
	localparam int E_W     = 48;
	localparam int SUM_W   = 56;
	localparam int CNT_W   = 7;

	localparam logic [24:0] UNIT_Q = 25'd27420721;

	localparam logic [F_W-1:0] POS_LIM = {1'b0, {(F_W-1){1'b1}}};
	localparam logic [F_W-1:0] NEG_LIM = {1'b1, {(F_W-1){1'b0}}};

	// controller states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_SRTI = 3'd2;
	localparam logic [2:0] S_SRT  = 3'd3;
	localparam logic [2:0] S_AE   = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	// serial multiplier operand selections
	localparam logic [1:0] MS_EE = 2'd0;  // ae * ae
	localparam logic [1:0] MS_EK = 2'd1;  // ae^2 * k
	localparam logic [1:0] MS_KA = 2'd2;  // 2*k*unit * ae
	localparam logic [1:0] MS_AX = 2'd3;  // previous * |diff| of one axis

	localparam logic [CNT_W-1:0] SQ_LAST  = 7'd3;
	localparam logic [CNT_W-1:0] SRT_LAST = 7'd33;
	localparam logic [CNT_W-1:0] MUL_LAST = 7'd36;
	localparam logic [CNT_W-1:0] DIV_LAST = 7'd95;

	typedef struct packed {
		logic       load_in;
		logic       sq_mul;
		logic       sq_acc;
		logic [1:0] axis;
		logic       srt_init;
		logic       srt_step;
		logic       ae_calc;
		logic       mul_start;
		logic       mul_step;
		logic       mul_save;
		logic [1:0] mul_sel;
		logic       div_start;
		logic       div_step;
		logic       f_store;
		logic       out_load;
	} hbf_cmd_t;

endpackage

@@ design/hbf_ctrl.sv @@
// hbf_ctrl: sequencer for one bond: squares, square root, serial multiplies
// and per-axis divides, then the output hand-off. Uses hbf_pkg.
module hbf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output hbf_pkg::hbf_cmd_t cmd
);

	logic [2:0]                state_q;
	logic [hbf_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]                phase_q;
	logic [1:0]                axis_q;
	logic                      out_valid_q;

	assign s_tready = (state_q == hbf_pkg::S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = phase_q;
		cmd.axis = axis_q;
		case (state_q)
			hbf_pkg::S_IDLE: begin
				cmd.load_in = s_tvalid;
			end
			hbf_pkg::S_SQ: begin
				cmd.sq_mul = (cnt_q < hbf_pkg::SQ_LAST);
				cmd.sq_acc = (cnt_q != '0);
				cmd.axis = (cnt_q < hbf_pkg::SQ_LAST) ? cnt_q[1:0] : 2'd2;
			end
			hbf_pkg::S_SRTI: cmd.srt_init = 1'b1;
			hbf_pkg::S_SRT:  cmd.srt_step = 1'b1;
			hbf_pkg::S_AE:   cmd.ae_calc = 1'b1;
			hbf_pkg::S_MUL: begin
				cmd.mul_start = (cnt_q == '0);
				cmd.mul_save = (cnt_q == hbf_pkg::MUL_LAST);
				cmd.mul_step = !cmd.mul_start && !cmd.mul_save;
			end
			hbf_pkg::S_DIV: begin
				cmd.div_start = (cnt_q == '0);
				cmd.f_store = (cnt_q == hbf_pkg::DIV_LAST);
				cmd.div_step = !cmd.div_start && !cmd.f_store;
			end
			hbf_pkg::S_DONE: cmd.out_load = !out_valid_q || m_tready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbf_pkg::S_IDLE;
			cnt_q <= '0;
			phase_q <= hbf_pkg::MS_EE;
			axis_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				hbf_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= hbf_pkg::S_SQ;
					end
				end
				hbf_pkg::S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == hbf_pkg::SQ_LAST) begin
						state_q <= hbf_pkg::S_SRTI;
					end
				end
				hbf_pkg::S_SRTI: begin
					cnt_q <= '0;
					state_q <= hbf_pkg::S_SRT;
				end
				hbf_pkg::S_SRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == hbf_pkg::SRT_LAST) begin
						state_q <= hbf_pkg::S_AE;
					end
				end
				hbf_pkg::S_AE: begin
					cnt_q <= '0;
					phase_q <= hbf_pkg::MS_EE;
					state_q <= hbf_pkg::S_MUL;
				end
				hbf_pkg::S_MUL: begin
					if (cnt_q == hbf_pkg::MUL_LAST) begin
						cnt_q <= '0;
						if (phase_q == hbf_pkg::MS_AX) begin
							state_q <= hbf_pkg::S_DIV;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				hbf_pkg::S_DIV: begin
					if (cnt_q == hbf_pkg::DIV_LAST) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= hbf_pkg::S_DONE;
						end else begin
							axis_q <= axis_q + 1'b1;
							state_q <= hbf_pkg::S_MUL;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				hbf_pkg::S_DONE: begin
					if (cmd.out_load) begin
						axis_q <= '0;
						phase_q <= hbf_pkg::MS_EE;
						state_q <= hbf_pkg::S_IDLE;
					end
				end
				default: state_q <= hbf_pkg::S_IDLE;
			endcase
		end
	end

endmodule

@@ design/hbf_dp.sv @@
// hbf_dp: datapath for one bond: squared distance, digit square root,
// shift-add multiplier, restoring divider and the energy accumulator. Uses hbf_pkg.
module hbf_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hbf_pkg::hbf_cmd_t         cmd,
	input  logic [hbf_pkg::IN_W-1:0]  s_tdata,
	input  logic                      s_tlast,
	output logic [hbf_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast,
	output logic                      m_tuser
);

	logic signed [hbf_pkg::DIFF_W-1:0] diff_q [3];
	logic [hbf_pkg::CRD_W-1:0]  adiff_q [3];
	logic [hbf_pkg::CRD_W-1:0]  k_q, d0_q;
	logic [hbf_pkg::IDX_W-1:0]  ia_q, ib_q;
	logic                       last_q;
	logic [63:0]                sqp_q;
	logic [65:0]                sq_q;
	logic [hbf_pkg::RAD_W-1:0]  rad_q;
	logic [hbf_pkg::SREM_W-1:0] srem_q;
	logic [hbf_pkg::ROOT_W-1:0] root_q;
	logic                       zero_q, eneg_q;
	logic [hbf_pkg::AE_W-1:0]   ae_q;
	logic [hbf_pkg::KU_W-1:0]   ku_q;
	logic [hbf_pkg::EE_W-1:0]   ee_q;
	logic [hbf_pkg::KUA_W-1:0]  kua_q;
	logic [hbf_pkg::MP_W-1:0]   ma_q, mp_q;
	logic [hbf_pkg::MB_W-1:0]   mb_q;
	logic [hbf_pkg::DV_W-1:0]   dv_q;
	logic [hbf_pkg::DREM_W-1:0] drem_q;
	logic [hbf_pkg::F_W-1:0]    f_q [3];
	logic [hbf_pkg::E_W-1:0]    energy_q;
	logic [hbf_pkg::SUM_W-1:0]  sum_q;

	logic signed [hbf_pkg::DIFF_W-1:0] dnew [3];
	logic [hbf_pkg::SREM_W+1:0] srem_t, strial;
	logic [hbf_pkg::DREM_W:0]   drem_t;
	logic [hbf_pkg::EE_W-1:0]   ew;
	logic [hbf_pkg::DV_W-1:0]   q;
	logic                       fneg, fover, fgate;
	logic [hbf_pkg::F_W-1:0]    flim, fm;
	logic [hbf_pkg::SUM_W:0]    total_w;
	logic [hbf_pkg::SUM_W-1:0]  total;
	logic [hbf_pkg::KU_W-2:0]   kup;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dnew[a] = $signed({s_tdata[96+32*a+31], s_tdata[96+32*a +: 32]})
				- $signed({s_tdata[32*a+31], s_tdata[32*a +: 32]});
		end
	end

	assign srem_t = {srem_q, rad_q[hbf_pkg::RAD_W-1 -: 2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign drem_t = {drem_q, dv_q[hbf_pkg::DV_W-1]};
	assign ew = mp_q[101:32];
	assign kup = k_q * hbf_pkg::UNIT_Q;

	// force magnitude from the quotient, clipped per sign
	assign q = dv_q;
	assign fneg = (eneg_q == diff_q[cmd.axis][hbf_pkg::DIFF_W-1]);
	assign flim = fneg ? hbf_pkg::NEG_LIM : hbf_pkg::POS_LIM;
	assign fover = (|q[hbf_pkg::DV_W-1:hbf_pkg::F_W]) || (q[hbf_pkg::F_W-1:0] > flim);
	assign fm = fover ? flim : q[hbf_pkg::F_W-1:0];
	assign fgate = !zero_q && (ae_q != '0) && (adiff_q[cmd.axis] != '0);

	assign total_w = {1'b0, sum_q} + {{(hbf_pkg::SUM_W-hbf_pkg::E_W+1){1'b0}}, energy_q};
	assign total = total_w[hbf_pkg::SUM_W] ? {hbf_pkg::SUM_W{1'b1}} : total_w[hbf_pkg::SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			for (int a = 0; a < 3; a++) begin
				diff_q[a] <= dnew[a];
				adiff_q[a] <= dnew[a][hbf_pkg::DIFF_W-1] ? hbf_pkg::CRD_W'(-dnew[a])
					: hbf_pkg::CRD_W'(dnew[a]);
			end
			k_q <= s_tdata[223:192];
			d0_q <= s_tdata[255:224];
			ia_q <= s_tdata[271:256];
			ib_q <= s_tdata[287:272];
			last_q <= s_tlast;
			sq_q <= '0;
		end
		if (cmd.sq_mul) begin
			sqp_q <= adiff_q[cmd.axis] * adiff_q[cmd.axis];
		end
		if (cmd.sq_acc) begin
			sq_q <= sq_q + {2'b00, sqp_q};
		end
		if (cmd.srt_init) begin
			rad_q <= {2'b00, sq_q};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.srt_step) begin
			rad_q <= {rad_q[hbf_pkg::RAD_W-3:0], 2'b00};
			if (srem_t >= strial) begin
				srem_q <= hbf_pkg::SREM_W'(srem_t - strial);
				root_q <= {root_q[hbf_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= hbf_pkg::SREM_W'(srem_t);
				root_q <= {root_q[hbf_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.ae_calc) begin
			zero_q <= (root_q == '0);
			eneg_q <= (root_q < {2'b00, d0_q});
			ae_q <= (root_q < {2'b00, d0_q}) ? ({2'b00, d0_q} - root_q)
				: (root_q - {2'b00, d0_q});
			ku_q <= {kup, 1'b0};
		end
		if (cmd.mul_start) begin
			mp_q <= '0;
			case (cmd.mul_sel)
				hbf_pkg::MS_EE: begin
					ma_q <= hbf_pkg::MP_W'(ae_q);
					mb_q <= hbf_pkg::MB_W'(ae_q);
				end
				hbf_pkg::MS_EK: begin
					ma_q <= hbf_pkg::MP_W'(ee_q);
					mb_q <= hbf_pkg::MB_W'(k_q);
				end
				hbf_pkg::MS_KA: begin
					ma_q <= hbf_pkg::MP_W'(ku_q);
					mb_q <= hbf_pkg::MB_W'(ae_q);
				end
				hbf_pkg::MS_AX: begin
					ma_q <= hbf_pkg::MP_W'(kua_q);
					mb_q <= hbf_pkg::MB_W'(adiff_q[cmd.axis]);
				end
				default: begin
					ma_q <= '0;
					mb_q <= '0;
				end
			endcase
		end
		if (cmd.mul_step) begin
			if (mb_q[0]) begin
				mp_q <= mp_q + ma_q;
			end
			ma_q <= {ma_q[hbf_pkg::MP_W-2:0], 1'b0};
			mb_q <= {1'b0, mb_q[hbf_pkg::MB_W-1:1]};
		end
		if (cmd.mul_save) begin
			case (cmd.mul_sel)
				hbf_pkg::MS_EE: ee_q <= mp_q[hbf_pkg::EE_W-1:0];
				hbf_pkg::MS_EK: energy_q <= (|ew[hbf_pkg::EE_W-1:hbf_pkg::E_W])
					? {hbf_pkg::E_W{1'b1}} : ew[hbf_pkg::E_W-1:0];
				hbf_pkg::MS_KA: kua_q <= mp_q[hbf_pkg::KUA_W-1:0];
				default: ;
			endcase
		end
		if (cmd.div_start) begin
			dv_q <= mp_q[125:32];
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			if (drem_t >= {2'b00, root_q}) begin
				drem_q <= hbf_pkg::DREM_W'(drem_t - {2'b00, root_q});
				dv_q <= {dv_q[hbf_pkg::DV_W-2:0], 1'b1};
			end else begin
				drem_q <= drem_t[hbf_pkg::DREM_W-1:0];
				dv_q <= {dv_q[hbf_pkg::DV_W-2:0], 1'b0};
			end
		end
		if (cmd.f_store) begin
			f_q[cmd.axis] <= !fgate ? '0 : (fneg ? -fm : fm);
		end
		if (cmd.out_load) begin
			m_tdata <= {total, energy_q, f_q[2], f_q[1], f_q[0], ib_q, ia_q};
			m_tlast <= last_q;
			m_tuser <= zero_q;
		end
	end

	// run total, restarted after the last bond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.out_load) begin
			sum_q <= last_q ? '0 : total;
		end
	end

endmodule

@@ design/harmonic_bond_force_top.sv @@
// Harmonic bond stretch force unit: one bond in, one force/energy result out.
// A new bond is taken the cycle after the result is loaded into the output
// register, so only one bond is in flight at a time; the multiplier and
// divider each work one bit per cycle.
// Reset (arst_n low) clears the sequencer, the output valid and the energy sum.
module harmonic_bond_force_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// xi, yi, zi, xj, yj, zj, stiffness, rest_length, first_atom, second_atom
	input  logic [hbf_pkg::IN_W-1:0]  s_tdata,
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// atom_a, atom_b, force_x, force_y, force_z, bond_energy, total_energy
	output logic [hbf_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast,
	// zero_length
	output logic                      m_tuser
);

	hbf_pkg::hbf_cmd_t cmd;

	hbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hbf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a bond is in flight");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared right after input");

	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[175:32] == '0))
		else $error("nonzero force for coinciding atoms");

	a_total_ge_bond: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[279:224] >= {8'h00, m_tdata[223:176]}))
		else $error("running energy below bond energy");
`endif

endmodule
